[design/cpeg_pkg.sv]
// Shared widths, codes, sequencer states and saturation helpers for the Coulomb pair block.
package cpeg_pkg;

    localparam int COORD_W   = 32;
    localparam int CHARGE_W  = 16;
    localparam int DIFF_W    = 33;   // coordinate difference magnitude
    localparam int SQ_W      = 65;   // one squared offset
    localparam int SUM_SQ_W  = 66;   // r^2
    localparam int ROOT_W    = 49;   // r, with extra root fraction bits
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int ROOT_EXTRA = 16;
    localparam int K_W       = 37;
    localparam int QQ_W      = 31;
    localparam int M_W       = 68;
    localparam int SR_W      = 115;  // widest divisor: r^2 * r
    localparam int NUM_W     = 101;  // widest dividend before alignment
    localparam int WR_W      = 33;
    localparam int QUO_W     = 64;
    localparam int OUT_W     = 48;
    localparam int ACC_W     = 64;
    localparam int CUT_W     = 48;
    localparam int DIEL_W    = 18;
    localparam int MUL_AW    = 68;
    localparam int MUL_BW    = 49;
    localparam int MUL_PW    = MUL_AW + MUL_BW;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 6;

    localparam logic [32:0]        COULOMB_Q24  = 33'd5570938724;
    localparam logic [CUT_W-1:0]   CUTOFF_RESET = 48'd6553600;
    localparam logic [DIEL_W-1:0]  UNITY_Q16    = 18'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF    = 2'd0,
        CFG_INV_DIEL  = 2'd1,
        CFG_INV_SCALE = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        REL_NORMAL   = 2'd0,
        REL_EXCLUDED = 2'd1,
        REL_ONE_FOUR = 2'd2
    } t_relation;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_CHK, S_ROOT, S_KD, S_KS, S_QQ, S_M,
        S_E, S_SR, S_GM, S_GD, S_WD, S_VM, S_VD, S_FIN
    } t_state;

    function automatic logic [OUT_W-1:0] sat48(input logic neg, input logic [QUO_W-1:0] mag);
        logic big;
        big = |mag[QUO_W-1:OUT_W-1];
        if (big)
            return neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        else
            return neg ? (~mag[OUT_W-1:0] + 1'b1) : mag[OUT_W-1:0];
    endfunction

    function automatic logic [ACC_W-1:0] sat_add64(input logic [ACC_W-1:0] a,
                                                   input logic [ACC_W-1:0] b);
        logic [ACC_W:0] sum;
        sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (sum[ACC_W] != sum[ACC_W-1])
            return sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            return sum[ACC_W-1:0];
    endfunction

endpackage

[design/cpeg_mul.sv]
// Serial shift-add multiplier, one multiplier bit per cycle, stops when the multiplier runs out.
module cpeg_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cpeg_pkg::MUL_AW-1:0] i_a,
    input  logic [cpeg_pkg::MUL_BW-1:0] i_b,
    output logic                        o_done,
    output logic [cpeg_pkg::MUL_PW-1:0] o_p
);
    logic                        r_busy;
    logic [cpeg_pkg::MUL_PW-1:0] r_a;
    logic [cpeg_pkg::MUL_PW-1:0] r_acc;
    logic [cpeg_pkg::MUL_BW-1:0] r_b;

    assign o_done = r_busy && (r_b == '0);
    assign o_p    = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= cpeg_pkg::MUL_PW'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy && !o_done) begin
            if (r_b[0])
                r_acc <= r_acc + r_a;
            r_a <= {r_a[cpeg_pkg::MUL_PW-2:0], 1'b0};
            r_b <= {1'b0, r_b[cpeg_pkg::MUL_BW-1:1]};
        end
    end
endmodule

[design/cpeg_sqrt.sv]
// Digit-by-digit integer square root, one root bit (two radicand bits) per cycle.
module cpeg_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cpeg_pkg::RAD_W-1:0]  i_rad,
    output logic                        o_done,
    output logic [cpeg_pkg::ROOT_W-1:0] o_root
);
    localparam int REM_W = cpeg_pkg::ROOT_W + 1;

    logic                         r_busy;
    logic [cpeg_pkg::CNT_W-1:0]   r_cnt;
    logic [cpeg_pkg::RAD_W-1:0]   r_rad;
    logic [REM_W-1:0]             r_rem;
    logic [cpeg_pkg::ROOT_W-1:0]  r_root;
    logic [REM_W+1:0]             rem4;
    logic [REM_W+1:0]             trial;
    logic [REM_W+1:0]             diff;
    logic                         ge;

    assign rem4   = {r_rem, r_rad[cpeg_pkg::RAD_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = rem4 >= trial;
    assign diff   = rem4 - trial;
    assign o_done = r_busy && (r_cnt == cpeg_pkg::CNT_W'(cpeg_pkg::ROOT_W));
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy && !o_done) begin
            r_rad  <= {r_rad[cpeg_pkg::RAD_W-3:0], 2'b00};
            r_rem  <= ge ? diff[REM_W-1:0] : rem4[REM_W-1:0];
            r_root <= {r_root[cpeg_pkg::ROOT_W-2:0], ge};
            r_cnt  <= r_cnt + 1'b1;
        end
    end
endmodule

[design/cpeg_div.sv]
// Restoring divider, one quotient bit per cycle; quotients at or above 2^63 hold at 2^63-1.
module cpeg_div #(
    parameter int XW = 149,
    parameter int DW = 115
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [XW-1:0]              i_x,
    input  logic [DW-1:0]              i_d,
    output logic                       o_done,
    output logic [cpeg_pkg::QUO_W-1:0] o_q
);
    localparam int LOW_W = cpeg_pkg::QUO_W - 1;
    localparam int HW    = XW - LOW_W;
    localparam int CW    = (HW > DW) ? HW : DW;

    logic                       r_busy;
    logic                       r_sat;
    logic [cpeg_pkg::CNT_W-1:0] r_cnt;
    logic [DW-1:0]              r_rem;
    logic [DW-1:0]              r_d;
    logic [LOW_W-1:0]           r_low;
    logic [LOW_W-1:0]           r_q;
    logic [CW-1:0]              head;
    logic [CW-1:0]              dext;
    logic                       sat_now;
    logic [DW:0]                rem2;
    logic [DW:0]                diff;
    logic                       ge;

    // high part of the dividend at or above the divisor means quotient >= 2^63
    assign head    = CW'(i_x[XW-1:LOW_W]);
    assign dext    = CW'(i_d);
    assign sat_now = head >= dext;
    assign rem2    = {r_rem, r_low[LOW_W-1]};
    assign ge      = rem2 >= {1'b0, r_d};
    assign diff    = rem2 - {1'b0, r_d};
    assign o_done  = r_busy && (r_sat || (r_cnt == cpeg_pkg::CNT_W'(LOW_W)));
    assign o_q     = r_sat ? {1'b0, {LOW_W{1'b1}}} : {1'b0, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat <= sat_now;
            r_rem <= sat_now ? '0 : head[DW-1:0];
            r_d   <= i_d;
            r_low <= i_x[LOW_W-1:0];
            r_q   <= '0;
            r_cnt <= '0;
        end else if (r_busy && !o_done) begin
            r_rem <= ge ? diff[DW-1:0] : rem2[DW-1:0];
            r_low <= {r_low[LOW_W-2:0], 1'b0};
            r_q   <= {r_q[LOW_W-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end
endmodule

[design/coulomb_pair_energy_gradient.sv]
// Coulomb pair energy, gradient and running virial with cutoff: top level with sequencer.
// One pair per transaction; a pair is taken only while the sequencer is idle, and its result
// goes to an output register, so the next pair may start while that result waits. A skipped
// pair takes three serial squares plus accept, filter and finish; coincident or near atoms
// finish sooner, since a short multiplier operand ends its square early. A contributing
// pair takes ten restoring divisions (a saturating one ends early), a square root and up to
// fourteen shift-add products, each of which stops once its multiplier operand has no set
// bits left. The serial divider and multiplier, one bit per cycle, set the length of a pair;
// a stalled result adds its wait on top.
// Energy and virial totals saturate and clear after the result of the pair flagged last.
module coulomb_pair_energy_gradient #(
    parameter int COORD_FRAC_BITS  = 16,
    parameter int CHARGE_FRAC_BITS = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write channel
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [47:0]   i_cfg_data,
    // input stream
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, first_charge, second_charge
    input  logic [223:0]  i_s_axis_tdata,
    // pair_relation[1:0], either_used[2]
    input  logic [2:0]    i_s_axis_tuser,
    input  logic          i_s_axis_tlast,   // last_pair
    // result stream
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // pair_energy, grad_x, grad_y, grad_z, total_energy, virial_x, virial_y, virial_z
    output logic [447:0]  o_m_axis_tdata,
    output logic          o_m_axis_tuser,   // counted
    output logic          o_m_axis_tlast    // end_of_set
);
    localparam int CF    = COORD_FRAC_BITS;
    localparam int QF    = CHARGE_FRAC_BITS;
    localparam int KE    = CF + cpeg_pkg::ROOT_EXTRA;
    localparam int KG    = 2 * CF + cpeg_pkg::ROOT_EXTRA - 2 * QF;
    localparam int KW    = 32;
    localparam int KV    = KE;
    localparam int KM1   = (KE > KG) ? KE : KG;
    localparam int KMAX  = (KM1 > KW) ? KM1 : KW;
    localparam int XW    = cpeg_pkg::NUM_W + KMAX;
    localparam int DW    = cpeg_pkg::SR_W;
    localparam int LIM_W = (cpeg_pkg::CUT_W + CF > cpeg_pkg::SUM_SQ_W) ?
                           cpeg_pkg::CUT_W + CF : cpeg_pkg::SUM_SQ_W;
    localparam int CW    = cpeg_pkg::COORD_W;
    localparam int QW    = cpeg_pkg::CHARGE_W;
    localparam int OW    = cpeg_pkg::OUT_W;
    localparam int AW    = cpeg_pkg::ACC_W;

    cpeg_pkg::t_state r_state, n_state;

    // configuration
    logic [cpeg_pkg::CUT_W-1:0]  r_cut;
    logic [cpeg_pkg::DIEL_W-1:0] r_inv_diel;
    logic [cpeg_pkg::DIEL_W-1:0] r_inv_scale;

    // per-pair working registers
    logic [1:0]                    r_ax;
    logic [cpeg_pkg::DIFF_W-1:0]   r_ad   [3];
    logic [2:0]                    r_dpos;
    logic [cpeg_pkg::SQ_W-1:0]     r_adsq [3];
    logic [QW-1:0]                 r_q1m, r_q2m;
    logic                          r_neg, r_qz, r_used, r_last, r_live;
    logic [1:0]                    r_rel;
    logic [cpeg_pkg::SUM_SQ_W-1:0] r_s;
    logic [cpeg_pkg::ROOT_W-1:0]   r_rho;
    logic [cpeg_pkg::K_W-1:0]      r_k;
    logic [cpeg_pkg::QQ_W-1:0]     r_qq;
    logic [cpeg_pkg::M_W-1:0]      r_m;
    logic [cpeg_pkg::SR_W-1:0]     r_sr;
    logic [cpeg_pkg::NUM_W-1:0]    r_tmp;
    logic [cpeg_pkg::WR_W-1:0]     r_wr;
    logic [cpeg_pkg::QUO_W-1:0]    r_eq;
    logic [cpeg_pkg::QUO_W-1:0]    r_gq [3];
    logic [cpeg_pkg::QUO_W-1:0]    r_vq [3];
    logic                          r_issued;

    // running sums
    logic [AW-1:0] r_esum, r_vsum [3];
    logic [AW-1:0] n_esum, n_vsum [3];

    // output register
    logic          r_out_valid;
    logic [447:0]  r_out_data;
    logic          r_out_user, r_out_last;

    // unit handshakes
    logic                          mul_start, mul_done, div_start, div_done, root_start, root_done;
    logic [cpeg_pkg::MUL_AW-1:0]   mul_a;
    logic [cpeg_pkg::MUL_BW-1:0]   mul_b;
    logic [cpeg_pkg::MUL_PW-1:0]   mul_p;
    logic [XW-1:0]                 div_x;
    logic [DW-1:0]                 div_d;
    logic [cpeg_pkg::QUO_W-1:0]    div_q;
    logic [cpeg_pkg::ROOT_W-1:0]   root_q;
    logic                          is_mul, is_div, is_root, step_done;

    logic                          accept, out_free, live;
    logic [cpeg_pkg::DIFF_W-1:0]   in_d  [3];
    logic [cpeg_pkg::DIFF_W-1:0]   in_ad [3];
    logic [QW-1:0]                 in_q1, in_q2;
    logic [LIM_W-1:0]              limit, s_ext;
    logic [OW-1:0]                 e48;
    logic [OW-1:0]                 g48 [3];
    logic [AW-1:0]                 vir [3];

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == cpeg_pkg::S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

    // offsets and magnitudes straight off the input bus
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_d[i]  = {i_s_axis_tdata[CW*i + CW-1], i_s_axis_tdata[CW*i +: CW]}
                     - {i_s_axis_tdata[CW*(i+3) + CW-1], i_s_axis_tdata[CW*(i+3) +: CW]};
            in_ad[i] = in_d[i][cpeg_pkg::DIFF_W-1] ? (~in_d[i] + 1'b1) : in_d[i];
        end
    end
    assign in_q1 = i_s_axis_tdata[6*CW +: QW];
    assign in_q2 = i_s_axis_tdata[6*CW+QW +: QW];

    // pair filter
    assign limit = LIM_W'(r_cut) << CF;
    assign s_ext = LIM_W'(r_s);
    assign live  = r_used && !r_qz && (s_ext < limit) && (r_s != '0) &&
                   (r_rel == cpeg_pkg::REL_NORMAL || r_rel == cpeg_pkg::REL_ONE_FOUR);

    assign is_mul  = r_state inside {cpeg_pkg::S_SQ, cpeg_pkg::S_KD, cpeg_pkg::S_KS,
                                     cpeg_pkg::S_QQ, cpeg_pkg::S_M, cpeg_pkg::S_SR,
                                     cpeg_pkg::S_GM, cpeg_pkg::S_VM};
    assign is_div  = r_state inside {cpeg_pkg::S_E, cpeg_pkg::S_GD, cpeg_pkg::S_WD,
                                     cpeg_pkg::S_VD};
    assign is_root = (r_state == cpeg_pkg::S_ROOT);
    assign mul_start  = is_mul && !r_issued;
    assign div_start  = is_div && !r_issued;
    assign root_start = is_root && !r_issued;
    assign step_done  = (is_mul && mul_done) || (is_div && div_done) || (is_root && root_done);

    // operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            cpeg_pkg::S_SQ: begin
                mul_a = cpeg_pkg::MUL_AW'(r_ad[r_ax]);
                mul_b = cpeg_pkg::MUL_BW'(r_ad[r_ax]);
            end
            cpeg_pkg::S_KD: begin
                mul_a = cpeg_pkg::MUL_AW'(cpeg_pkg::COULOMB_Q24);
                mul_b = cpeg_pkg::MUL_BW'(r_inv_diel);
            end
            cpeg_pkg::S_KS: begin
                mul_a = cpeg_pkg::MUL_AW'(r_k);
                mul_b = cpeg_pkg::MUL_BW'(r_inv_scale);
            end
            cpeg_pkg::S_QQ: begin
                mul_a = cpeg_pkg::MUL_AW'(r_q1m);
                mul_b = cpeg_pkg::MUL_BW'(r_q2m);
            end
            cpeg_pkg::S_M: begin
                mul_a = cpeg_pkg::MUL_AW'(r_k);
                mul_b = cpeg_pkg::MUL_BW'(r_qq);
            end
            cpeg_pkg::S_SR: begin
                mul_a = cpeg_pkg::MUL_AW'(r_s);
                mul_b = r_rho;
            end
            cpeg_pkg::S_GM: begin
                mul_a = r_m;
                mul_b = cpeg_pkg::MUL_BW'(r_ad[r_ax]);
            end
            cpeg_pkg::S_VM: begin
                mul_a = r_m;
                mul_b = cpeg_pkg::MUL_BW'(r_wr);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_x = '0;
        div_d = '0;
        case (r_state)
            cpeg_pkg::S_E: begin
                div_x = XW'(r_m) << KE;
                div_d = DW'(r_rho) << (2 * QF);
            end
            cpeg_pkg::S_GD: begin
                div_x = XW'(r_tmp) << KG;
                div_d = r_sr;
            end
            cpeg_pkg::S_WD: begin
                div_x = XW'(r_adsq[r_ax]) << KW;
                div_d = DW'(r_s);
            end
            cpeg_pkg::S_VD: begin
                div_x = XW'(r_tmp) << KV;
                div_d = DW'(r_rho) << (KW + 2 * QF);
            end
            default: begin
                div_x = '0;
                div_d = '0;
            end
        endcase
    end

    cpeg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    cpeg_div #(.XW(XW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_x     (div_x),
        .i_d     (div_d),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    cpeg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_rad   ({r_s, {(cpeg_pkg::RAD_W-cpeg_pkg::SUM_SQ_W){1'b0}}}),
        .o_done  (root_done),
        .o_root  (root_q)
    );

    // result assembly and sum update
    always_comb begin
        e48 = r_live ? cpeg_pkg::sat48(r_neg, r_eq) : '0;
        n_esum = r_live ? cpeg_pkg::sat_add64(r_esum, {{(AW-OW){e48[OW-1]}}, e48}) : r_esum;
        for (int i = 0; i < 3; i++) begin
            g48[i]    = r_live ? cpeg_pkg::sat48(r_dpos[i] ? !r_neg : r_neg, r_gq[i]) : '0;
            vir[i]    = r_neg ? r_vq[i] : (~r_vq[i] + 1'b1);
            n_vsum[i] = r_live ? cpeg_pkg::sat_add64(r_vsum[i], vir[i]) : r_vsum[i];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            cpeg_pkg::S_IDLE: if (accept) n_state = cpeg_pkg::S_SQ;
            cpeg_pkg::S_SQ:   if (step_done && r_ax == 2'd2) n_state = cpeg_pkg::S_CHK;
            cpeg_pkg::S_CHK:  n_state = live ? cpeg_pkg::S_ROOT : cpeg_pkg::S_FIN;
            cpeg_pkg::S_ROOT: if (step_done) n_state = cpeg_pkg::S_KD;
            cpeg_pkg::S_KD: begin
                if (step_done)
                    n_state = (r_rel == cpeg_pkg::REL_ONE_FOUR) ? cpeg_pkg::S_KS
                                                                : cpeg_pkg::S_QQ;
            end
            cpeg_pkg::S_KS:   if (step_done) n_state = cpeg_pkg::S_QQ;
            cpeg_pkg::S_QQ:   if (step_done) n_state = cpeg_pkg::S_M;
            cpeg_pkg::S_M:    if (step_done) n_state = cpeg_pkg::S_E;
            cpeg_pkg::S_E:    if (step_done) n_state = cpeg_pkg::S_SR;
            cpeg_pkg::S_SR:   if (step_done) n_state = cpeg_pkg::S_GM;
            cpeg_pkg::S_GM:   if (step_done) n_state = cpeg_pkg::S_GD;
            cpeg_pkg::S_GD:   if (step_done) n_state = cpeg_pkg::S_WD;
            cpeg_pkg::S_WD:   if (step_done) n_state = cpeg_pkg::S_VM;
            cpeg_pkg::S_VM:   if (step_done) n_state = cpeg_pkg::S_VD;
            cpeg_pkg::S_VD: begin
                if (step_done)
                    n_state = (r_ax == 2'd2) ? cpeg_pkg::S_FIN : cpeg_pkg::S_GM;
            end
            cpeg_pkg::S_FIN:  if (out_free) n_state = cpeg_pkg::S_IDLE;
            default:          n_state = cpeg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpeg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control state: config, unit issue flag, axis counter, sums, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut       <= cpeg_pkg::CUTOFF_RESET;
            r_inv_diel  <= cpeg_pkg::UNITY_Q16;
            r_inv_scale <= cpeg_pkg::UNITY_Q16;
            r_issued    <= 1'b0;
            r_ax        <= '0;
            r_esum      <= '0;
            for (int i = 0; i < 3; i++) r_vsum[i] <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == cpeg_pkg::CFG_CUTOFF)
                    r_cut <= i_cfg_data;
                else if (i_cfg_index == cpeg_pkg::CFG_INV_DIEL)
                    r_inv_diel <= i_cfg_data[cpeg_pkg::DIEL_W-1:0];
                else if (i_cfg_index == cpeg_pkg::CFG_INV_SCALE)
                    r_inv_scale <= i_cfg_data[cpeg_pkg::DIEL_W-1:0];
            end

            if (mul_start || div_start || root_start)
                r_issued <= 1'b1;
            else if (step_done)
                r_issued <= 1'b0;

            if (step_done && (r_state == cpeg_pkg::S_SQ || r_state == cpeg_pkg::S_VD))
                r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;

            if (r_out_valid && i_m_axis_tready)
                r_out_valid <= 1'b0;

            if (r_state == cpeg_pkg::S_FIN && out_free) begin
                r_out_valid <= 1'b1;
                r_esum      <= r_last ? '0 : n_esum;
                for (int i = 0; i < 3; i++) r_vsum[i] <= r_last ? '0 : n_vsum[i];
            end
        end
    end

    // datapath captures
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                r_ad[i]   <= in_ad[i];
                r_dpos[i] <= !in_d[i][cpeg_pkg::DIFF_W-1] && (in_d[i] != '0);
            end
            r_q1m  <= in_q1[QW-1] ? (~in_q1 + 1'b1) : in_q1;
            r_q2m  <= in_q2[QW-1] ? (~in_q2 + 1'b1) : in_q2;
            r_neg  <= in_q1[QW-1] ^ in_q2[QW-1];
            r_qz   <= (in_q1 == '0) || (in_q2 == '0);
            r_rel  <= i_s_axis_tuser[1:0];
            r_used <= i_s_axis_tuser[2];
            r_last <= i_s_axis_tlast;
            r_s    <= '0;
        end

        if (r_state == cpeg_pkg::S_CHK)
            r_live <= live;

        if (step_done) begin
            case (r_state)
                cpeg_pkg::S_SQ: begin
                    r_adsq[r_ax] <= mul_p[cpeg_pkg::SQ_W-1:0];
                    r_s <= r_s + cpeg_pkg::SUM_SQ_W'(mul_p[cpeg_pkg::SQ_W-1:0]);
                end
                cpeg_pkg::S_ROOT: r_rho <= root_q;
                cpeg_pkg::S_KD:   r_k   <= cpeg_pkg::K_W'(mul_p[50:16]);
                cpeg_pkg::S_KS:   r_k   <= mul_p[16 +: cpeg_pkg::K_W];
                cpeg_pkg::S_QQ:   r_qq  <= mul_p[cpeg_pkg::QQ_W-1:0];
                cpeg_pkg::S_M:    r_m   <= mul_p[cpeg_pkg::M_W-1:0];
                cpeg_pkg::S_E:    r_eq  <= div_q;
                cpeg_pkg::S_SR:   r_sr  <= mul_p[cpeg_pkg::SR_W-1:0];
                cpeg_pkg::S_GM:   r_tmp <= mul_p[cpeg_pkg::NUM_W-1:0];
                cpeg_pkg::S_GD:   r_gq[r_ax] <= div_q;
                cpeg_pkg::S_WD:   r_wr  <= div_q[cpeg_pkg::WR_W-1:0];
                cpeg_pkg::S_VM:   r_tmp <= mul_p[cpeg_pkg::NUM_W-1:0];
                cpeg_pkg::S_VD:   r_vq[r_ax] <= div_q;
                default: ;
            endcase
        end

        if (r_state == cpeg_pkg::S_FIN && out_free) begin
            r_out_data <= {n_vsum[2], n_vsum[1], n_vsum[0], n_esum,
                           g48[2], g48[1], g48[0], e48};
            r_out_user <= r_live;
            r_out_last <= r_last;
        end
    end
endmodule
